// ===== hdl/ba_pkg.sv =====
// Shared constants and codes for the buddy allocator.
`default_nettype none
package ba_pkg;
    localparam int unsigned DEF_ENTRIES   = 512;
    localparam int unsigned DEF_MIN_BLOCK = 32;
    localparam int unsigned HDR_W         = 16;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned SIZE_W        = 16;
    localparam int unsigned STAT_W        = 2;
    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h2000_1000;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADADDR  = 2'd2;
endpackage
`default_nettype wire

// ===== hdl/ba_hdr_mem.sv =====
// Block header memory with a clearing sweep after reset.
`default_nettype none
module ba_hdr_mem
    import ba_pkg::*;
#(
    parameter int unsigned ENTRIES   = DEF_ENTRIES,
    parameter int unsigned MIN_BLOCK = DEF_MIN_BLOCK
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  wire logic [HDR_W-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic      [HDR_W-1:0]           rd_data,
    output logic                            ready
);
    localparam int unsigned IW = $clog2(ENTRIES);
    localparam logic [HDR_W-1:0] HEAP_HDR = HDR_W'(ENTRIES * MIN_BLOCK);

    logic [HDR_W-1:0] mem [ENTRIES];
    logic [IW:0]      clr_cnt_reg;
    logic             clr_busy_reg;
    logic [HDR_W-1:0] rd_data_reg;
    logic [HDR_W-1:0] clr_data;

    assign clr_data = (clr_cnt_reg == '0) ? HEAP_HDR : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (IW+1)'(ENTRIES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg[IW-1:0]] <= clr_data;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;
endmodule
`default_nettype wire

// ===== hdl/ba_seq.sv =====
// Sequencer: block search, split bookkeeping and buddy merging over the header read and write ports.
`default_nettype none
module ba_seq
    import ba_pkg::*;
#(
    parameter int unsigned ENTRIES   = DEF_ENTRIES,
    parameter int unsigned MIN_BLOCK = DEF_MIN_BLOCK
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       cmd,
    input  wire logic [SIZE_W-1:0]          req_size,
    input  wire logic [ADDR_W-1:0]          free_addr,
    input  wire logic [ADDR_W-1:0]          heap_base,
    input  wire logic                       mem_ready,
    output logic                            wr_en,
    output logic      [$clog2(ENTRIES)-1:0] wr_addr,
    output logic      [HDR_W-1:0]           wr_data,
    output logic                            rd_en,
    output logic      [$clog2(ENTRIES)-1:0] rd_addr,
    input  wire logic [HDR_W-1:0]           rd_data,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output logic      [ADDR_W-1:0]          res_addr,
    output logic      [STAT_W-1:0]          res_status
);
    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned MW = $clog2(MIN_BLOCK);
    localparam int unsigned RW = IW + MW + 1;
    localparam int unsigned CW = (RW > SIZE_W) ? RW : SIZE_W;
    localparam logic [CW-1:0] HEAP_C   = CW'(ENTRIES * MIN_BLOCK);
    localparam logic [CW-1:0] MIN_C    = CW'(MIN_BLOCK);
    localparam logic [ADDR_W:0] OFF_MAX = (ADDR_W+1)'(ENTRIES * MIN_BLOCK - MIN_BLOCK);
    localparam logic [IW:0] ENT_N = (IW+1)'(ENTRIES);
    localparam logic [IW:0] ONE_N = (IW+1)'(1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ASIZE  = 4'd1;
    localparam logic [3:0] S_APROBE = 4'd2;
    localparam logic [3:0] S_APCHK  = 4'd3;
    localparam logic [3:0] S_AUP    = 4'd4;
    localparam logic [3:0] S_AUPCHK = 4'd5;
    localparam logic [3:0] S_FRD    = 4'd6;
    localparam logic [3:0] S_FCHK   = 4'd7;
    localparam logic [3:0] S_FBCHK  = 4'd8;
    localparam logic [3:0] S_FZERO  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IW:0]       stride_reg, stride_next;
    logic [IW:0]       pos_reg, pos_next;
    logic [IW:0]       c_reg, c_next;
    logic [IW:0]       b_reg, b_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [HDR_W-1:0]  v_reg, v_next;
    logic              odd_reg, odd_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [STAT_W-1:0] pend_stat_reg, pend_stat_next;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [STAT_W-1:0] out_stat_reg;

    logic              in_fire, out_load;
    logic [ADDR_W:0]   off;
    logic [CW-1:0]     region, hdr_c, size_c, v_c;
    logic [IW:0]       pos_step, mid, n_val, b_val;
    logic [HDR_W-1:0]  v_val;
    logic              odd_val;

    assign in_ready = (state_reg == S_IDLE) && mem_ready;
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || res_ready);

    always_comb begin
        off      = {1'b0, free_addr} - {1'b0, heap_base};
        region   = CW'(stride_reg) << MW;
        hdr_c    = CW'(rd_data);
        size_c   = CW'(size_reg);
        pos_step = pos_reg + stride_reg;
        mid      = (pos_reg & ~((c_reg << 1) - ONE_N)) | c_reg;
        v_val    = {rd_data[HDR_W-1:1], 1'b0};
        v_c      = CW'(v_val);
        n_val    = (IW+1)'(v_val >> MW);
        odd_val  = |({1'b0, idx_reg} & n_val);
        b_val    = odd_val ? ({1'b0, idx_reg} - n_val) : ({1'b0, idx_reg} + n_val);
    end

    always_comb begin
        state_next     = state_reg;
        size_next      = size_reg;
        stride_next    = stride_reg;
        pos_next       = pos_reg;
        c_next         = c_reg;
        b_next         = b_reg;
        idx_next       = idx_reg;
        v_next         = v_reg;
        odd_next       = odd_reg;
        pend_addr_next = pend_addr_reg;
        pend_stat_next = pend_stat_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    size_next      = req_size;
                    stride_next    = ONE_N;
                    pend_addr_next = '0;
                    if (cmd == CMD_ALLOC) begin
                        if (CW'(req_size) < MIN_C || CW'(req_size) > HEAP_C) begin
                            pend_stat_next = ST_NOSPACE;
                            state_next     = S_DONE;
                        end else begin
                            state_next = S_ASIZE;
                        end
                    end else begin
                        if (off[ADDR_W] || off > OFF_MAX) begin
                            pend_stat_next = ST_BADADDR;
                            state_next     = S_DONE;
                        end else begin
                            idx_next       = off[MW+IW-1:MW];
                            pend_addr_next = free_addr;
                            pend_stat_next = ST_OK;
                            state_next     = S_FRD;
                        end
                    end
                end
            end
            S_ASIZE: begin
                // double the block until it holds the request
                if (region < size_c) begin
                    stride_next = stride_reg << 1;
                end else begin
                    pos_next   = '0;
                    state_next = S_APROBE;
                end
            end
            S_APROBE: begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg[IW-1:0];
                state_next = S_APCHK;
            end
            S_APCHK: begin
                if (!rd_data[0] && hdr_c >= region) begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[IW-1:0];
                    wr_data    = HDR_W'(region) | HDR_W'(1);
                    c_next     = stride_reg;
                    state_next = S_AUP;
                end else if (pos_step >= ENT_N) begin
                    pend_stat_next = ST_NOSPACE;
                    state_next     = S_DONE;
                end else begin
                    pos_next   = pos_step;
                    state_next = S_APROBE;
                end
            end
            S_AUP: begin
                // mark right buddies of every split where the block went left
                if (c_reg >= ENT_N) begin
                    pend_addr_next = heap_base + ADDR_W'(CW'(pos_reg) << MW);
                    pend_stat_next = ST_OK;
                    state_next     = S_DONE;
                end else if ((pos_reg & c_reg) == '0) begin
                    rd_en      = 1'b1;
                    rd_addr    = mid[IW-1:0];
                    b_next     = mid;
                    state_next = S_AUPCHK;
                end else begin
                    c_next = c_reg << 1;
                end
            end
            S_AUPCHK: begin
                if (rd_data == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = b_reg[IW-1:0];
                    wr_data = HDR_W'(CW'(c_reg) << MW);
                end
                c_next     = c_reg << 1;
                state_next = S_AUP;
            end
            S_FRD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_FCHK;
            end
            S_FCHK: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = v_val;
                v_next  = v_val;
                odd_next = odd_val;
                b_next  = b_val;
                if (n_val == '0 || v_c >= HEAP_C || (!odd_val && b_val >= ENT_N)) begin
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = b_val[IW-1:0];
                    state_next = S_FBCHK;
                end
            end
            S_FBCHK: begin
                if (rd_data != v_reg) begin
                    state_next = S_DONE;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = odd_reg ? b_reg[IW-1:0] : idx_reg;
                    wr_data    = v_reg << 1;
                    state_next = S_FZERO;
                end
            end
            S_FZERO: begin
                wr_en   = 1'b1;
                wr_addr = odd_reg ? idx_reg : b_reg[IW-1:0];
                wr_data = '0;
                if (odd_reg) begin
                    idx_next = b_reg[IW-1:0];
                end
                state_next = S_FRD;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        size_reg      <= size_next;
        stride_reg    <= stride_next;
        pos_reg       <= pos_next;
        c_reg         <= c_next;
        b_reg         <= b_next;
        idx_reg       <= idx_next;
        v_reg         <= v_next;
        odd_reg       <= odd_next;
        pend_addr_reg <= pend_addr_next;
        pend_stat_reg <= pend_stat_next;
        if (out_load) begin
            out_addr_reg <= pend_addr_reg;
            out_stat_reg <= pend_stat_reg;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_addr   = out_addr_reg;
    assign res_status = out_stat_reg;

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("header read and write hit the same entry");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && pend_stat_reg != ST_OK) |-> (pend_addr_reg == '0))
        else $error("failed item carries a nonzero address");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after accepting an item");
endmodule
`default_nettype wire

// ===== hdl/buddy_allocator.sv =====
// Top level of the buddy allocator: stream ports, heap base register, sequencer and headers.
//
//   channel | direction | handshake                  | payload
//   s_      | in        | s_tvalid / s_tready        | s_tdata, s_tuser (command)
//   m_      | out       | m_tvalid / m_tready        | m_tdata (address, status)
//   cfg_    | in        | cfg_valid / cfg_ready      | cfg_data (heap base)
//
// After reset the header table is swept entry by entry; s_tready stays low meanwhile.
// Allocate: the size is doubled until the block holds the request, then candidate blocks are
// probed through the one header read port (up to all ENTRIES for the smallest size), then each
// tree level is visited. Free: the header is read and cleared, then each merge level reads the
// buddy, writes the merged header and zeroes the other; a buddy that does not match ends it.
// One item at a time; a finished result is held in the output register until taken.
`default_nettype none
module buddy_allocator
    import ba_pkg::*;
#(
    parameter int unsigned ENTRIES   = DEF_ENTRIES,
    parameter int unsigned MIN_BLOCK = DEF_MIN_BLOCK
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // request_size[15:0], free_address[47:16]
    input  wire logic [0:0]  s_tuser,   // cmd[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // result_address[31:0], status[33:32], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    localparam int unsigned IW = $clog2(ENTRIES);

    logic [ADDR_W-1:0] heap_base_reg;
    logic              mem_ready, wr_en, rd_en;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic [HDR_W-1:0]  wr_data, rd_data;
    logic [ADDR_W-1:0] res_addr;
    logic [STAT_W-1:0] res_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= BASE_RESET;
        end else if (cfg_valid) begin
            heap_base_reg <= cfg_data;
        end
    end

    ba_hdr_mem #(.ENTRIES(ENTRIES), .MIN_BLOCK(MIN_BLOCK)) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .ready   (mem_ready)
    );

    ba_seq #(.ENTRIES(ENTRIES), .MIN_BLOCK(MIN_BLOCK)) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tuser[0]),
        .req_size   (s_tdata[15:0]),
        .free_addr  (s_tdata[47:16]),
        .heap_base  (heap_base_reg),
        .mem_ready  (mem_ready),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_addr   (res_addr),
        .res_status (res_status)
    );

    assign m_tdata = {6'd0, res_status, res_addr};
endmodule
`default_nettype wire
